>>> src/vcirb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcirb_pkg
// Shared types, port codes and helpers for the video chip interrupt and
// register block.
// ----------------------------------------------------------------------------
package vcirb_pkg;

  // Register store geometry (supported range 64..256 entries).
  localparam int STORE_DEPTH = 256;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  // Worst-case subtract steps to fold an 8-bit port into the store.
  localparam int FOLD_STEPS  = 255 / STORE_DEPTH;
  localparam logic [8:0] DEPTH_9 = 9'(STORE_DEPTH);

  // Item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // Event sources
  localparam logic [1:0] SRC_KEYBOARD   = 2'd0;
  localparam logic [1:0] SRC_VERTICAL   = 2'd1;
  localparam logic [1:0] SRC_HORIZONTAL = 2'd2;
  localparam logic [1:0] SRC_TIMER      = 2'd3;

  // Decoded ports
  localparam logic [7:0] PORT_INIT       = 8'h90;
  localparam logic [7:0] PORT_IRQ_STEER  = 8'h92;
  localparam logic [7:0] PORT_FIRQ_STEER = 8'h93;
  localparam logic [7:0] PORT_TIMER_HI   = 8'h94;
  localparam logic [7:0] PORT_TIMER_LO   = 8'h95;
  localparam logic [7:0] PORT_VOFF_HI    = 8'h9D;
  localparam logic [7:0] PORT_VOFF_LO    = 8'h9E;

  localparam logic [7:0] TIMER_READ_VALUE = 8'd126;

  // Shadow copies of the store entries that drive side outputs.
  localparam int SHADOW_N  = 6;
  localparam int SH_IRQ    = 0;
  localparam int SH_FIRQ   = 1;
  localparam int SH_TMR_HI = 2;
  localparam int SH_TMR_LO = 3;
  localparam int SH_VOF_HI = 4;
  localparam int SH_VOF_LO = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] addr;
    logic [7:0] write_data;
    logic [1:0] source;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        firq_raise;
    logic        irq_raise;
    logic [3:0]  source_enables;
    logic        timer_load;
    logic [11:0] timer_reload;
    logic        offset_load;
    logic [15:0] vert_offset;
  } rsp_item_t;

  // Port number to store entry (port mod STORE_DEPTH).
  function automatic logic [IDX_W-1:0] slot_of(input logic [7:0] port);
    logic [8:0] v;
    v = {1'b0, port};
    for (int i = 0; i < FOLD_STEPS; i++) begin
      if (v >= DEPTH_9) begin
        v = v - DEPTH_9;
      end
    end
    return v[IDX_W-1:0];
  endfunction

  function automatic logic [7:0] shadow_port(input int unsigned idx);
    logic [7:0] p;
    case (idx)
      SH_IRQ:    p = PORT_IRQ_STEER;
      SH_FIRQ:   p = PORT_FIRQ_STEER;
      SH_TMR_HI: p = PORT_TIMER_HI;
      SH_TMR_LO: p = PORT_TIMER_LO;
      SH_VOF_HI: p = PORT_VOFF_HI;
      default:   p = PORT_VOFF_LO;
    endcase
    return p;
  endfunction

  // Steering bit for each source.
  function automatic logic [5:0] source_mask(input logic [1:0] src);
    logic [5:0] m;
    case (src)
      SRC_KEYBOARD:   m = 6'b00_0010;
      SRC_VERTICAL:   m = 6'b00_1000;
      SRC_HORIZONTAL: m = 6'b01_0000;
      default:        m = 6'b10_0000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> src/vcirb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcirb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vcirb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/video_chip_interrupt_register_block_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_chip_interrupt_register_block_top
// Register file and interrupt router of a video/memory chip.
// ----------------------------------------------------------------------------
// Each request transfer is a bus write, a bus read or an interrupt event and
// yields exactly one response transfer, in order. The block takes one request
// per clock: a request is registered together with the store read issued at
// acceptance, does all its work in the following cycle and lands in the
// response register, so throughput is one transfer per cycle while the
// response side keeps up. The response register decouples the two sides; a
// stalled response holds one request in the work stage and the request side
// stalls only when both are full. The byte store lives in a one-write,
// one-read RAM; per-entry valid bits cleared by reset make the store read as
// zero after reset, so no clearing pass is needed. A write from the retiring
// request to the entry the new request reads is forwarded. The steering,
// timer and offset entries are also mirrored in flops so routing,
// source enables, the timer reload and the vertical offset need no extra RAM
// ports. Reads of the steering ports return and clear the IRQ/FIRQ latches;
// reads of the timer ports return 126. Events route to FIRQ first, then IRQ.
// ----------------------------------------------------------------------------
module video_chip_interrupt_register_block_top
  import vcirb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  // Work stage
  logic             s1_valid;
  req_item_t        s1_item;
  logic             s1_fwd_hit;     // retiring write hit the entry read at accept
  logic [7:0]       s1_fwd_data;
  logic             s1_entry_valid; // entry written since reset
  logic             s1_adv;
  logic             req_fire;

  // Architectural state
  logic [7:0]       shadow      [SHADOW_N];
  logic [7:0]       shadow_next [SHADOW_N];
  logic [5:0]       irq_latch;
  logic [5:0]       irq_latch_next;
  logic [5:0]       firq_latch;
  logic [5:0]       firq_latch_next;
  logic             irq_en;
  logic             irq_en_next;
  logic             firq_en;
  logic             firq_en_next;
  logic [STORE_DEPTH-1:0] entry_valid;

  // Store access
  logic [IDX_W-1:0] req_slot;
  logic [IDX_W-1:0] wr_slot;
  logic             wr_en;
  logic [7:0]       ram_q;
  logic [7:0]       stored_byte;

  // Decode of the item in the work stage
  logic             is_write;
  logic             is_read;
  logic             is_event;
  logic [5:0]       ev_mask;
  logic             firq_hit;
  logic             irq_hit;
  logic [7:0]       steer_or;
  rsp_item_t        result;

  assign req_fire  = req_valid && req_ready;
  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;

  assign req_slot = slot_of(req.addr);
  assign wr_slot  = slot_of(s1_item.addr);
  assign is_write = (s1_item.kind == KIND_WRITE);
  assign is_read  = (s1_item.kind == KIND_READ);
  assign is_event = (s1_item.kind == KIND_EVENT);
  assign wr_en    = s1_adv && is_write;

  vcirb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot),
    .wdata (s1_item.write_data),
    .re    (req_fire),
    .raddr (req_slot),
    .rdata (ram_q)
  );

  // Work stage register; store read data arrives alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_item        <= req;
      s1_fwd_hit     <= wr_en && (wr_slot == req_slot);
      s1_fwd_data    <= s1_item.write_data;
      s1_entry_valid <= entry_valid[req_slot];
    end
  end

  always_comb begin
    if (s1_fwd_hit) begin
      stored_byte = s1_fwd_data;
    end else if (s1_entry_valid) begin
      stored_byte = ram_q;
    end else begin
      stored_byte = 8'h00;
    end
  end

  // Mirrors of the side-effect entries, matched by store entry so that
  // aliasing in a smaller store behaves like the RAM.
  always_comb begin
    for (int i = 0; i < SHADOW_N; i++) begin
      if (is_write && (wr_slot == slot_of(shadow_port(i)))) begin
        shadow_next[i] = s1_item.write_data;
      end else begin
        shadow_next[i] = shadow[i];
      end
    end
  end

  // Event routing: FIRQ wins over IRQ.
  assign ev_mask  = source_mask(s1_item.source);
  assign firq_hit = is_event && firq_en && ((shadow[SH_FIRQ][5:0] & ev_mask) != 6'd0);
  assign irq_hit  = is_event && !firq_hit && irq_en &&
                    ((shadow[SH_IRQ][5:0] & ev_mask) != 6'd0);

  always_comb begin
    irq_en_next     = irq_en;
    firq_en_next    = firq_en;
    irq_latch_next  = irq_latch;
    firq_latch_next = firq_latch;
    if (is_write && (s1_item.addr == PORT_INIT)) begin
      firq_en_next = s1_item.write_data[4];
      irq_en_next  = s1_item.write_data[5];
    end
    if (is_read && (s1_item.addr == PORT_IRQ_STEER)) begin
      irq_latch_next = 6'd0;
    end
    if (is_read && (s1_item.addr == PORT_FIRQ_STEER)) begin
      firq_latch_next = 6'd0;
    end
    if (firq_hit) begin
      firq_latch_next = firq_latch | ev_mask;
    end
    if (irq_hit) begin
      irq_latch_next = irq_latch | ev_mask;
    end
  end

  // Result for the item in the work stage
  assign steer_or = shadow_next[SH_IRQ] | shadow_next[SH_FIRQ];

  always_comb begin
    result                = '0;
    result.firq_raise     = firq_hit;
    result.irq_raise      = irq_hit;
    result.source_enables = {steer_or[5], steer_or[4], steer_or[3], steer_or[1]};
    if (is_read) begin
      if (s1_item.addr == PORT_IRQ_STEER) begin
        result.read_data = {2'b00, irq_latch};
      end else if (s1_item.addr == PORT_FIRQ_STEER) begin
        result.read_data = {2'b00, firq_latch};
      end else if ((s1_item.addr == PORT_TIMER_HI) || (s1_item.addr == PORT_TIMER_LO)) begin
        result.read_data = TIMER_READ_VALUE;
      end else begin
        result.read_data = stored_byte;
      end
    end
    if (is_write && ((s1_item.addr == PORT_TIMER_HI) || (s1_item.addr == PORT_TIMER_LO))) begin
      result.timer_load   = 1'b1;
      result.timer_reload = {shadow_next[SH_TMR_HI][3:0], shadow_next[SH_TMR_LO]};
    end
    if (is_write && ((s1_item.addr == PORT_VOFF_HI) || (s1_item.addr == PORT_VOFF_LO))) begin
      result.offset_load = 1'b1;
      result.vert_offset = {shadow_next[SH_VOF_HI], shadow_next[SH_VOF_LO]};
    end
  end

  // State commits when the item retires into the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_latch   <= '0;
      firq_latch  <= '0;
      irq_en      <= 1'b0;
      firq_en     <= 1'b0;
      entry_valid <= '0;
      for (int i = 0; i < SHADOW_N; i++) begin
        shadow[i] <= 8'h00;
      end
    end else if (s1_adv) begin
      irq_latch  <= irq_latch_next;
      firq_latch <= firq_latch_next;
      irq_en     <= irq_en_next;
      firq_en    <= firq_en_next;
      if (is_write) begin
        entry_valid[wr_slot] <= 1'b1;
      end
      for (int i = 0; i < SHADOW_N; i++) begin
        shadow[i] <= shadow_next[i];
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= s1_adv || (rsp_valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= result;
    end
  end

endmodule
`default_nettype wire
